// ===== rtl/sps_pkg.sv =====
package sps_pkg;

  localparam int unsigned SLOT_BYTES = 4;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned HALF_W     = 16;

  typedef enum logic [1:0] {
    OP_INS_START = 2'd0,
    OP_INS_DATA  = 2'd1,
    OP_READ      = 2'd2,
    OP_NEW_PAGE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_FULL = 3'd1,
    ST_SEQ  = 3'd2,
    ST_SLOT = 3'd3,
    ST_POS  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_WR_SLOT,
    MEM_WR_DATA,
    MEM_RD_ENTRY,
    MEM_RD_TUPLE
  } mem_op_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_START,
    UPD_DATA,
    UPD_NEW_PAGE
  } upd_t;

  typedef struct packed {
    logic    load_in;
    mem_op_t mem_op;
    logic [1:0] byte_sel;
    logic    cap_entry;
    logic [1:0] cap_sel;
    logic    cap_tuple;
    upd_t    upd;
    logic    res_load;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    active;
    logic    room_fail;
    logic    slot_bad;
    logic    pos_bad;
    logic    size_gt_end;
  } stat_t;

endpackage

// ===== rtl/sps_ctrl.sv =====
module sps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sps_pkg::stat_t    stat,
  output sps_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WR_SLOT,
    S_START,
    S_RD_ENTRY,
    S_RD_LAST,
    S_CHECK,
    S_RD_TUPLE,
    S_RESULT
  } state_t;

  state_t           state;
  logic [1:0]       k;
  sps_pkg::status_t res_status;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.mem_op     = sps_pkg::MEM_NONE;
    cmd.upd        = sps_pkg::UPD_NONE;
    cmd.res_status = res_status;
    cmd.byte_sel   = k;
    unique case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        if (stat.op == sps_pkg::OP_NEW_PAGE) begin
          cmd.upd = sps_pkg::UPD_NEW_PAGE;
        end else if (stat.op == sps_pkg::OP_INS_DATA && stat.active) begin
          cmd.mem_op = sps_pkg::MEM_WR_DATA;
          cmd.upd    = sps_pkg::UPD_DATA;
        end
      end
      S_WR_SLOT: begin
        cmd.mem_op = sps_pkg::MEM_WR_SLOT;
      end
      S_START: begin
        cmd.upd = sps_pkg::UPD_START;
      end
      S_RD_ENTRY: begin
        // Read data arrives in the cycle after its address.
        cmd.mem_op    = sps_pkg::MEM_RD_ENTRY;
        cmd.cap_entry = (k != 2'd0);
        cmd.cap_sel   = k - 2'd1;
      end
      S_RD_LAST: begin
        cmd.cap_entry = 1'b1;
        cmd.cap_sel   = 2'd3;
      end
      S_CHECK: begin
        if (!stat.pos_bad && !stat.size_gt_end) begin
          cmd.mem_op = sps_pkg::MEM_RD_TUPLE;
        end
      end
      S_RD_TUPLE: begin
        cmd.cap_tuple = 1'b1;
      end
      S_RESULT: begin
        cmd.res_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      k          <= 2'd0;
      res_status <= sps_pkg::ST_OK;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          k <= 2'd0;
          unique case (stat.op)
            sps_pkg::OP_INS_START: begin
              if (stat.active) begin
                res_status <= sps_pkg::ST_SEQ;
                state      <= S_RESULT;
              end else if (stat.room_fail) begin
                res_status <= sps_pkg::ST_FULL;
                state      <= S_RESULT;
              end else begin
                res_status <= sps_pkg::ST_OK;
                state      <= S_WR_SLOT;
              end
            end
            sps_pkg::OP_INS_DATA: begin
              if (!stat.active) begin
                res_status <= sps_pkg::ST_SEQ;
              end else begin
                res_status <= sps_pkg::ST_OK;
              end
              state <= S_RESULT;
            end
            sps_pkg::OP_READ: begin
              if (stat.slot_bad) begin
                res_status <= sps_pkg::ST_SLOT;
                state      <= S_RESULT;
              end else begin
                res_status <= sps_pkg::ST_OK;
                state      <= S_RD_ENTRY;
              end
            end
            sps_pkg::OP_NEW_PAGE: begin
              res_status <= sps_pkg::ST_OK;
              state      <= S_RESULT;
            end
            default: begin
              res_status <= sps_pkg::ST_OK;
              state      <= S_RESULT;
            end
          endcase
        end
        S_WR_SLOT: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_RESULT;
        end
        S_RD_ENTRY: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_RD_LAST;
          end
        end
        S_RD_LAST: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.pos_bad) begin
            res_status <= sps_pkg::ST_POS;
            state      <= S_RESULT;
          end else if (stat.size_gt_end) begin
            state <= S_RESULT;
          end else begin
            state <= S_RD_TUPLE;
          end
        end
        S_RD_TUPLE: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (cmd.res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sps_datapath.sv =====
module sps_datapath #(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sps_pkg::cmd_t                  cmd,
  output sps_pkg::stat_t                 stat,
  input  sps_pkg::opcode_t               opcode,
  input  logic [sps_pkg::LEN_W-1:0]      tuple_length,
  input  logic [sps_pkg::BYTE_W-1:0]     data_byte,
  input  logic [sps_pkg::SLOT_W-1:0]     slot_index,
  input  logic [sps_pkg::POS_W-1:0]      byte_position,
  output logic [sps_pkg::STAT_W-1:0]     status,
  output logic [sps_pkg::BYTE_W-1:0]     read_byte,
  output logic [sps_pkg::LEN_W-1:0]      tuple_size,
  output logic [sps_pkg::COUNT_W-1:0]    slot_count,
  output logic                           insert_done
);

  localparam int unsigned AW = $clog2(PAGE_BYTES);
  localparam int unsigned WW = ((AW > sps_pkg::LEN_W) ? AW : sps_pkg::LEN_W) + 2;
  localparam int unsigned SW = (AW > sps_pkg::COUNT_W) ? AW : sps_pkg::COUNT_W;

  logic [sps_pkg::BYTE_W-1:0] mem [PAGE_BYTES];
  logic [sps_pkg::BYTE_W-1:0] mem_rdata;
  logic [AW-1:0]              mem_addr;
  logic [sps_pkg::BYTE_W-1:0] mem_wdata;
  logic                       mem_we;

  sps_pkg::opcode_t           op;
  logic [sps_pkg::LEN_W-1:0]  len;
  logic [sps_pkg::BYTE_W-1:0] dbyte;
  logic [sps_pkg::SLOT_W-1:0] slot;
  logic [sps_pkg::POS_W-1:0]  pos;

  logic [AW-1:0]              count;
  logic [AW-1:0]              free_end;
  logic [AW-1:0]              cursor;
  logic [sps_pkg::LEN_W-1:0]  remaining;
  logic [sps_pkg::LEN_W-1:0]  pending;
  logic                       active;
  logic                       done;
  logic [3:0][7:0]            entry;
  logic [sps_pkg::BYTE_W-1:0] rbyte;

  logic [WW-1:0]              next_slot;
  logic [AW-1:0]              entry_base;
  logic [sps_pkg::HALF_W-1:0] end_w;
  logic [sps_pkg::HALF_W-1:0] size_w;
  logic [sps_pkg::HALF_W-1:0] fe16;
  logic [sps_pkg::HALF_W-1:0] len16;
  logic [sps_pkg::HALF_W-1:0] tuple_addr;
  logic [SW-1:0]              count_ext;
  logic [sps_pkg::LEN_W-1:0]  size_res;

  assign next_slot  = WW'(HEADER_BYTES) + (WW'(count) << 2);
  assign entry_base = AW'(HEADER_BYTES) + (AW'(slot) << 2);
  assign end_w      = {entry[0], entry[1]};
  assign size_w     = {entry[2], entry[3]};
  assign fe16       = sps_pkg::HALF_W'(free_end);
  assign len16      = sps_pkg::HALF_W'(len);
  assign tuple_addr = end_w - size_w + sps_pkg::HALF_W'(pos);
  assign count_ext  = SW'(count);

  always_comb begin
    stat.op          = op;
    stat.active      = active;
    // Written as a sum on the right so nothing can wrap below zero.
    stat.room_fail   = WW'(free_end) < (next_slot + WW'(sps_pkg::SLOT_BYTES) + WW'(len));
    stat.slot_bad    = SW'(slot) >= count_ext;
    stat.pos_bad     = sps_pkg::HALF_W'(pos) >= size_w;
    stat.size_gt_end = size_w > end_w;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = dbyte;
    unique case (cmd.mem_op)
      sps_pkg::MEM_WR_SLOT: begin
        mem_we   = 1'b1;
        mem_addr = next_slot[AW-1:0] + AW'(cmd.byte_sel);
        unique case (cmd.byte_sel)
          2'd0:    mem_wdata = fe16[15:8];
          2'd1:    mem_wdata = fe16[7:0];
          2'd2:    mem_wdata = len16[15:8];
          default: mem_wdata = len16[7:0];
        endcase
      end
      sps_pkg::MEM_WR_DATA: begin
        mem_we   = 1'b1;
        mem_addr = cursor;
      end
      sps_pkg::MEM_RD_ENTRY: begin
        mem_addr = entry_base + AW'(cmd.byte_sel);
      end
      sps_pkg::MEM_RD_TUPLE: begin
        mem_addr = tuple_addr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  always_comb begin
    unique case (op)
      sps_pkg::OP_INS_START: size_res = (cmd.res_status == sps_pkg::ST_SEQ) ? '0 : len;
      sps_pkg::OP_INS_DATA:  size_res = (cmd.res_status == sps_pkg::ST_SEQ) ? '0 : pending;
      sps_pkg::OP_READ:      size_res = (cmd.res_status == sps_pkg::ST_SLOT) ? '0 :
                                        size_w[sps_pkg::LEN_W-1:0];
      default:               size_res = '0;
    endcase
  end

  // Input capture, entry bytes and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op    <= opcode;
      len   <= tuple_length;
      dbyte <= data_byte;
      slot  <= slot_index;
      pos   <= byte_position;
      rbyte <= '0;
    end
    if (cmd.cap_entry) begin
      entry[cmd.cap_sel] <= mem_rdata;
    end
    if (cmd.cap_tuple) begin
      rbyte <= mem_rdata;
    end
    if (cmd.res_load) begin
      status      <= cmd.res_status;
      read_byte   <= rbyte;
      tuple_size  <= size_res;
      slot_count  <= count_ext[sps_pkg::COUNT_W-1:0];
      insert_done <= done;
    end
  end

  // Page bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      free_end  <= AW'(PAGE_BYTES - 1);
      cursor    <= '0;
      remaining <= '0;
      pending   <= '0;
      active    <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        done <= 1'b0;
      end
      unique case (cmd.upd)
        sps_pkg::UPD_START: begin
          cursor  <= free_end - AW'(len);
          pending <= len;
          if (len == '0) begin
            count     <= count + 1'b1;
            remaining <= '0;
            active    <= 1'b0;
            done      <= 1'b1;
          end else begin
            remaining <= len;
            active    <= 1'b1;
          end
        end
        sps_pkg::UPD_DATA: begin
          cursor <= cursor + 1'b1;
          if (remaining == sps_pkg::LEN_W'(1)) begin
            count     <= count + 1'b1;
            free_end  <= free_end - AW'(pending);
            remaining <= '0;
            active    <= 1'b0;
            done      <= 1'b1;
          end else begin
            remaining <= remaining - 1'b1;
          end
        end
        sps_pkg::UPD_NEW_PAGE: begin
          count     <= '0;
          free_end  <= AW'(PAGE_BYTES - 1);
          cursor    <= '0;
          remaining <= '0;
          pending   <= '0;
          active    <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_active_has_bytes: assert property (@(posedge clk) disable iff (rst)
    active |-> (remaining != '0))
    else $error("insert active with no bytes remaining");

  a_idle_no_bytes: assert property (@(posedge clk) disable iff (rst)
    !active |-> (remaining == '0))
    else $error("bytes remaining with no insert active");

  a_data_needs_insert: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd == sps_pkg::UPD_DATA) |-> active)
    else $error("data byte stored outside an insert");

  a_done_closes_insert: assert property (@(posedge clk) disable iff (rst)
    done |-> !active)
    else $error("insert reported done while still active");
`endif

endmodule

// ===== rtl/slotted_page_tuple_store.sv =====
// Slotted page of PAGE_BYTES bytes in a single-port byte memory: a header of
// HEADER_BYTES, then four-byte big-endian slot entries (end offset, size) growing
// upward, and tuples growing downward from just below the last byte. Every item
// returns exactly one result. The block works on one item at a time and every memory
// access uses the single port: an accepted insert start writes the four slot-entry
// bytes in turn, and a read fetches four entry bytes, then one tuple byte unless the
// position is out of range or the entry is inconsistent. A new item is taken while
// the previous result still waits on the output. The memory needs no clearing after
// reset; only written bytes are ever read.
module slotted_page_tuple_store #(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], tuple_length[13:2], data_byte[21:14], slot_index[31:22],
  // byte_position[43:32], zero fill up to bit 47.
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], read_byte[10:3], tuple_size[22:11], slot_count[32:23],
  // insert_done[33], zero fill up to bit 39.
  output logic [39:0] m_axis_tdata
);

  sps_pkg::cmd_t                    cmd;
  sps_pkg::stat_t                   stat;
  logic [sps_pkg::STAT_W-1:0]       status;
  logic [sps_pkg::BYTE_W-1:0]       read_byte;
  logic [sps_pkg::LEN_W-1:0]        tuple_size;
  logic [sps_pkg::COUNT_W-1:0]      slot_count;
  logic                             insert_done;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sps_datapath #(
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (sps_pkg::opcode_t'(s_axis_tdata[1:0])),
    .tuple_length  (s_axis_tdata[13:2]),
    .data_byte     (s_axis_tdata[21:14]),
    .slot_index    (s_axis_tdata[31:22]),
    .byte_position (s_axis_tdata[43:32]),
    .status        (status),
    .read_byte     (read_byte),
    .tuple_size    (tuple_size),
    .slot_count    (slot_count),
    .insert_done   (insert_done)
  );

  assign m_axis_tdata = {6'd0, insert_done, slot_count, tuple_size, read_byte, status};

endmodule
